// ===== hw/rtl/mdas_pkg.sv =====
// package for the multidimensional array store: sizes, codes, command type
// and the dimension-count helper. no dependencies.
`default_nettype none

package mdas_pkg;

  // array geometry
  localparam int MAX_DIMS    = 4;
  localparam int FIELD_DIMS  = 4;
  localparam int DIM_LIM     = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;
  localparam int STORE_DEPTH = 4096;
  localparam int ELEM_W      = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int IDX_W      = 12;
  localparam int EXT_W      = 13;
  localparam int DIMS_W     = 3;
  localparam int DIM_IDX_W  = $clog2(FIELD_DIMS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = EXT_W;
  localparam int STATUS_W   = 2;

  // horner step arithmetic
  localparam int PROD_W = ADDR_W + EXT_W;
  localparam int SUM_W  = ((PROD_W > IDX_W) ? PROD_W : IDX_W) + 1;

  // command queue between front and back
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXT_0 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EXT_3 = CFG_IDX_W'(4);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_INDEX = 2'd1,
    STATUS_BOUND = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CALC,
    FE_PUSH
  } front_state_t;

  typedef logic [FIELD_DIMS-1:0][EXT_W-1:0] ext_vec_t;
  typedef logic [FIELD_DIMS-1:0][IDX_W-1:0] idx_vec_t;

  // one classified access, front to back
  typedef struct packed {
    logic              is_write;
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] wdata;
  } cmd_t;

  // last dimension in use: zero acts as one, large values saturate
  function automatic logic [DIM_IDX_W-1:0] dims_last_of(input logic [DIMS_W-1:0] v);
    logic [DIM_IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > DIM_LIM) begin
      r = DIM_IDX_W'(DIM_LIM - 1);
    end else begin
      r = DIM_IDX_W'(v - 1'b1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mdas_ram.sv =====
// generic single-port ram with registered read data.
// no dependencies.
`default_nettype none

module mdas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, held while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mdas_front.sv =====
// front end: accepts access beats, checks indexes and builds the row-major
// offset by horner steps on one multiplier. depends on mdas_pkg.
`default_nettype none

module mdas_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              func,
  input  wire mdas_pkg::idx_vec_t                idx_in,
  input  wire logic [mdas_pkg::ELEM_W-1:0]       write_data,
  input  wire logic [mdas_pkg::DIM_IDX_W-1:0]    dims_last,
  input  wire mdas_pkg::ext_vec_t                ext,
  input  wire logic                              q_full,
  output logic                                   push,
  output mdas_pkg::cmd_t                         cmd
);

  mdas_pkg::front_state_t                 state;
  mdas_pkg::front_state_t                 state_next;
  mdas_pkg::idx_vec_t                     idx_r;
  logic [mdas_pkg::DIM_IDX_W-1:0]         step;
  logic                                   load;
  logic                                   step_en;
  logic                                   idx_err;
  logic                                   bound0;
  logic                                   start_calc;
  logic [mdas_pkg::PROD_W-1:0]            prod;
  logic [mdas_pkg::SUM_W-1:0]             sum;
  logic                                   sum_ovf;
  logic                                   calc_done;

  // index checks on the incoming beat, dimensions in use only
  always_comb begin
    idx_err = 1'b0;
    for (int i = 0; i < mdas_pkg::FIELD_DIMS; i++) begin
      if (mdas_pkg::DIM_IDX_W'(i) <= dims_last &&
          mdas_pkg::EXT_W'(idx_in[i]) >= ext[i]) begin
        idx_err = 1'b1;
      end
    end
  end

  assign bound0 = mdas_pkg::SUM_W'(idx_in[0]) >= mdas_pkg::SUM_W'(mdas_pkg::STORE_DEPTH);
  assign start_calc = !idx_err && !bound0 && (dims_last != '0);

  // horner step: partial offset times next extent plus next index
  assign prod = mdas_pkg::PROD_W'(cmd.addr) * mdas_pkg::PROD_W'(ext[step]);
  assign sum = mdas_pkg::SUM_W'(prod) + mdas_pkg::SUM_W'(idx_r[step]);
  assign sum_ovf = sum >= mdas_pkg::SUM_W'(mdas_pkg::STORE_DEPTH);
  assign calc_done = sum_ovf || (step == dims_last);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdas_pkg::FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    step_en    = 1'b0;
    case (state)
      mdas_pkg::FE_IDLE: begin
        in_ready = 1'b1;
      end
      mdas_pkg::FE_CALC: begin
        step_en = 1'b1;
        if (calc_done) begin
          state_next = mdas_pkg::FE_PUSH;
        end
      end
      mdas_pkg::FE_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          in_ready   = 1'b1;
          state_next = mdas_pkg::FE_IDLE;
        end
      end
      default: begin
        state_next = mdas_pkg::FE_IDLE;
      end
    endcase
    load = in_ready && in_valid;
    if (load) begin
      state_next = start_calc ? mdas_pkg::FE_CALC : mdas_pkg::FE_PUSH;
    end
  end

  // command and working registers
  always_ff @(posedge clk) begin
    if (load) begin
      cmd.is_write <= (func == mdas_pkg::FUNC_WRITE);
      cmd.wdata    <= write_data;
      cmd.addr     <= mdas_pkg::ADDR_W'(idx_in[0]);
      cmd.status   <= idx_err ? mdas_pkg::STATUS_INDEX :
                      bound0  ? mdas_pkg::STATUS_BOUND : mdas_pkg::STATUS_OK;
      idx_r        <= idx_in;
      step         <= mdas_pkg::DIM_IDX_W'(1);
    end else if (step_en) begin
      if (sum_ovf) begin
        cmd.status <= mdas_pkg::STATUS_BOUND;
      end else begin
        cmd.addr <= sum[mdas_pkg::ADDR_W-1:0];
      end
      step <= step + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mdas_queue.sv =====
// short command queue between the front and back ends.
// depends on mdas_pkg.
`default_nettype none

module mdas_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mdas_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output mdas_pkg::cmd_t      dout
);

  mdas_pkg::cmd_t               entries [mdas_pkg::Q_DEPTH];
  logic [mdas_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [mdas_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [mdas_pkg::Q_CNT_W-1:0] count;

  assign full      = count == mdas_pkg::Q_CNT_W'(mdas_pkg::Q_DEPTH);
  assign not_empty = count != '0;
  assign dout      = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mdas_pkg::Q_PTR_W'(mdas_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mdas_pkg::Q_PTR_W'(mdas_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mdas_back.sv =====
// back end: takes classified commands, performs the store access and holds
// the result beat. depends on mdas_pkg and mdas_ram.
`default_nettype none

module mdas_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire mdas_pkg::cmd_t              q_cmd,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mdas_pkg::ELEM_W-1:0]      read_data,
  output logic [mdas_pkg::STATUS_W-1:0]    status
);

  logic                          acc_valid;
  logic                          acc_read;
  mdas_pkg::status_t             acc_status;
  logic                          advance;
  logic                          access_ok;
  logic                          ram_we;
  logic                          ram_re;
  logic [mdas_pkg::ELEM_W-1:0]   ram_rdata;

  // access stage moves to the output register when that is free or taken
  assign advance   = !out_valid || out_ready;
  assign pop       = q_valid && (!acc_valid || advance);
  assign access_ok = q_cmd.status == mdas_pkg::STATUS_OK;
  assign ram_we    = pop && access_ok && q_cmd.is_write;
  assign ram_re    = pop && access_ok && !q_cmd.is_write;

  mdas_ram #(
    .WIDTH (mdas_pkg::ELEM_W),
    .DEPTH (mdas_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (q_cmd.addr),
    .wdata (q_cmd.wdata),
    .rdata (ram_rdata)
  );

  // access stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (pop) begin
      acc_valid <= 1'b1;
    end else if (advance) begin
      acc_valid <= 1'b0;
    end
  end

  // access stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      acc_read   <= access_ok && !q_cmd.is_write;
      acc_status <= q_cmd.status;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_valid && advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload, zero data unless a good read
  always_ff @(posedge clk) begin
    if (acc_valid && advance) begin
      read_data <= acc_read ? ram_rdata : '0;
      status    <= acc_status;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multidim_array_address_store_core.sv =====
// top level of the multidimensional array store: configuration registers,
// front end, command queue and back end. depends on mdas_pkg and submodules.
//
// usage:
//   configure dims_in_use (index 0) and extent_0..extent_3 (indexes 1..4)
//   through cfg_we/cfg_index/cfg_wdata while no access is in flight.
//   each input beat (func, index_0..index_3, write_data) is a read or a
//   write of one element at the row-major offset of its indexes; each gives
//   exactly one result beat (read_data, status) in order.
//   status 0 is ok, 1 an index at or past its extent, 2 an offset past the
//   end of the 4096-word store; read_data is zero unless a good read.
//   the horner steps are d - 1 for d dimensions in use, fewer once the
//   offset passes the store end, none on an index error. the front end
//   runs them on a single multiplier (multiply by the next extent, add the
//   next index) and takes no new beat before it pushes the last one; the
//   store port takes one access a cycle while the output is not stalled.
//   a two-deep command queue lets the front end keep accepting while the
//   output stalls; a stalled output holds its beat until taken.
//   reset clears control state and config (one dimension, zero extents);
//   store contents are not cleared and read undefined until written.
`default_nettype none

module multidim_array_address_store_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mdas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mdas_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             func,
  input  wire logic [mdas_pkg::IDX_W-1:0]       index_0,
  input  wire logic [mdas_pkg::IDX_W-1:0]       index_1,
  input  wire logic [mdas_pkg::IDX_W-1:0]       index_2,
  input  wire logic [mdas_pkg::IDX_W-1:0]       index_3,
  input  wire logic signed [mdas_pkg::ELEM_W-1:0] write_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [mdas_pkg::ELEM_W-1:0]    read_data,
  output logic [mdas_pkg::STATUS_W-1:0]         status
);

  logic [mdas_pkg::DIM_IDX_W-1:0] dims_last;
  mdas_pkg::ext_vec_t             ext;
  mdas_pkg::idx_vec_t             idx_in;
  mdas_pkg::cmd_t                 front_cmd;
  mdas_pkg::cmd_t                 q_cmd;
  logic                           push;
  logic                           q_full;
  logic                           pop;
  logic                           q_valid;
  logic [mdas_pkg::ELEM_W-1:0]    rd_data;

  assign idx_in    = {index_3, index_2, index_1, index_0};
  assign read_data = rd_data;

  // configuration registers, dimension count kept as last dimension index
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_last <= '0;
      ext       <= '0;
    end else if (cfg_we) begin
      if (cfg_index == mdas_pkg::REG_DIMS) begin
        dims_last <= mdas_pkg::dims_last_of(cfg_wdata[mdas_pkg::DIMS_W-1:0]);
      end else if (cfg_index >= mdas_pkg::REG_EXT_0 && cfg_index <= mdas_pkg::REG_EXT_3) begin
        ext[mdas_pkg::DIM_IDX_W'(cfg_index - mdas_pkg::REG_EXT_0)] <= cfg_wdata;
      end
    end
  end

  mdas_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .idx_in     (idx_in),
    .write_data (write_data),
    .dims_last  (dims_last),
    .ext        (ext),
    .q_full     (q_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  mdas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (front_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .dout      (q_cmd)
  );

  mdas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (rd_data),
    .status    (status)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mdas_checker.sv =====
// port-level checks for the multidimensional array store, bound to the top
// level. depends on mdas_pkg.
`default_nettype none

module mdas_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire logic signed [mdas_pkg::ELEM_W-1:0] read_data,
  input  wire logic [mdas_pkg::STATUS_W-1:0]    status
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown right after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
    else $error("stalled result beat changed");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == mdas_pkg::STATUS_OK || status == mdas_pkg::STATUS_INDEX ||
                   status == mdas_pkg::STATUS_BOUND))
    else $error("undefined status code");

  // a failed access returns zero data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mdas_pkg::STATUS_OK |-> read_data == '0)
    else $error("nonzero data on failed access");

endmodule

bind multidim_array_address_store_core mdas_checker u_mdas_checker (.*);

`default_nettype wire

// ===== test/tb_multidim_array_address_store_core.sv =====
`timescale 1ns / 100ps
// testbench for multidim_array_address_store_core: directed and random element
// reads and writes over several array geometries, checked beat by beat
// against a behavioral copy of the array store. depends on mdas_pkg and the core.

module tb_multidim_array_address_store_core;
  import mdas_pkg::*;

  // one access as presented on the input channel
  typedef struct packed {
    func_t             fn;
    idx_vec_t          idx;
    logic [ELEM_W-1:0] wdata;
  } access_t;

  // one reply as seen on the output channel
  typedef struct packed {
    logic [ELEM_W-1:0] rdata;
    status_t           st;
  } elem_reply_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [CFG_W-1:0]         cfg_wdata  = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic                     func       = 1'b0;
  logic [IDX_W-1:0]         index_0    = '0;
  logic [IDX_W-1:0]         index_1    = '0;
  logic [IDX_W-1:0]         index_2    = '0;
  logic [IDX_W-1:0]         index_3    = '0;
  logic signed [ELEM_W-1:0] write_data = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic signed [ELEM_W-1:0] read_data;
  logic [STATUS_W-1:0]      status;

  // geometry as the block holds it, starting from its reset values
  logic [DIMS_W-1:0] arr_dims = DIMS_W'(1);
  logic [EXT_W-1:0]  arr_extent [FIELD_DIMS] = '{default: '0};

  // element contents at acceptance time, and which offsets the stimulus has stored
  logic [ELEM_W-1:0] elem_mem [STORE_DEPTH];
  bit                gen_written [STORE_DEPTH];
  int unsigned       written_offs [$];

  access_t     access_beats [$];
  elem_reply_t element_replies [$];
  access_t     cur_beat;
  int          send_idle_pct = 35;
  int          recv_idle_pct = 54;
  int          reply_errors  = 0;

  multidim_array_address_store_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .index_0    (index_0),
    .index_1    (index_1),
    .index_2    (index_2),
    .index_3    (index_3),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .status     (status)
  );

  always #6 clk = ~clk;

  // dimension count after clamping: zero acts as one, large values saturate
  function automatic int unsigned dims_active();
    if (arr_dims == 0) return 1;
    if (arr_dims > DIM_LIM) return DIM_LIM;
    return arr_dims;
  endfunction

  // index checks in dimension order, then row-major offset and store bound
  function automatic status_t locate_element(input idx_vec_t ix,
                                             output longint unsigned off);
    int unsigned d;
    d   = dims_active();
    off = 0;
    for (int i = 0; i < d; i++) begin
      if (ix[i] >= arr_extent[i]) return STATUS_INDEX;
      off = off * arr_extent[i] + ix[i];
    end
    if (off >= STORE_DEPTH) return STATUS_BOUND;
    return STATUS_OK;
  endfunction

  // apply one accepted access to the element store and queue its reply
  function automatic void perform_access(input access_t a);
    longint unsigned off;
    elem_reply_t     r;
    r.rdata = '0;
    r.st    = locate_element(a.idx, off);
    if (r.st == STATUS_OK) begin
      if (a.fn == FUNC_WRITE) elem_mem[off[ADDR_W-1:0]] = a.wdata;
      else r.rdata = elem_mem[off[ADDR_W-1:0]];
    end
    element_replies.push_back(r);
  endfunction

  // queue a beat; a good read of a never-stored element turns into a store
  function automatic void enqueue_access(input access_t a);
    longint unsigned off;
    if (locate_element(a.idx, off) == STATUS_OK) begin
      if (a.fn == FUNC_READ && !gen_written[off]) a.fn = FUNC_WRITE;
      if (a.fn == FUNC_WRITE && !gen_written[off]) begin
        gen_written[off] = 1'b1;
        written_offs.push_back(int'(off));
      end
    end
    access_beats.push_back(a);
  endfunction

  function automatic void add_access(input func_t f, input int unsigned i0, i1, i2, i3,
                                     input logic [ELEM_W-1:0] wd);
    access_t a;
    a.fn     = f;
    a.idx[0] = IDX_W'(i0);
    a.idx[1] = IDX_W'(i1);
    a.idx[2] = IDX_W'(i2);
    a.idx[3] = IDX_W'(i3);
    a.wdata  = wd;
    enqueue_access(a);
  endfunction

  // random index inside the extent where the field can hold one
  function automatic logic [IDX_W-1:0] pick_index(input int i);
    int unsigned top;
    top = (arr_extent[i] > (1 << IDX_W)) ? (1 << IDX_W) : arr_extent[i];
    if (top == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, top - 1));
  endfunction

  // mostly stores and read-backs inside the array, some boundary and noise beats
  task automatic add_random_accesses(input int n);
    access_t     a;
    int unsigned d, pick, k, off;
    bit          hit;
    d = dims_active();
    repeat (n) begin
      a.fn    = func_t'($urandom_range(0, 1));
      a.wdata = $urandom;
      for (int i = 0; i < FIELD_DIMS; i++) a.idx[i] = IDX_W'($urandom);
      pick = $urandom_range(0, 99);
      hit  = 1'b0;
      if (pick >= 40 && pick < 75 && written_offs.size() != 0) begin
        // read back a stored element, offset split into indexes
        off = written_offs[$urandom_range(0, written_offs.size() - 1)];
        hit = 1'b1;
        for (int i = d - 1; i > 0; i--) begin
          if (arr_extent[i] == 0) begin
            hit = 1'b0;
          end else begin
            a.idx[i] = IDX_W'(off % arr_extent[i]);
            off      = off / arr_extent[i];
          end
        end
        if (off >= (1 << IDX_W)) hit = 1'b0;
        a.idx[0] = IDX_W'(off);
        if (hit) a.fn = FUNC_READ;
      end
      if (!hit) begin
        if (pick < 88) begin
          for (int i = 0; i < d; i++) a.idx[i] = pick_index(i);
          if (pick < 40) a.fn = FUNC_WRITE;
        end else if (pick < 94) begin
          // one index right at its extent
          k = $urandom_range(0, d - 1);
          for (int i = 0; i < d; i++) a.idx[i] = pick_index(i);
          if (arr_extent[k] < (1 << IDX_W)) a.idx[k] = IDX_W'(arr_extent[k]);
        end
      end
      enqueue_access(a);
    end
  endtask

  // one register write per cycle; the caller lowers the enable
  task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input int unsigned v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= CFG_W'(v);
    if (r == REG_DIMS) arr_dims = DIMS_W'(v);
    else if (r >= REG_EXT_0 && r <= REG_EXT_3) arr_extent[r - REG_EXT_0] = EXT_W'(v);
  endtask

  task automatic set_geometry(input int unsigned dims, e0, e1, e2, e3);
    write_reg(REG_DIMS, dims);
    write_reg(REG_EXT_0, e0);
    write_reg(CFG_IDX_W'(REG_EXT_0 + 1), e1);
    write_reg(CFG_IDX_W'(REG_EXT_0 + 2), e2);
    write_reg(CFG_IDX_W'(REG_EXT_0 + 3), e3);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all beats sent and answered, then a further wait for the pipeline to settle
  task automatic wait_drained();
    do @(posedge clk);
    while (access_beats.size() != 0 || in_valid || element_replies.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) perform_access(cur_beat);
      if (!in_valid || in_ready) begin
        if (access_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_beat = access_beats.pop_front();
          in_valid   <= 1'b1;
          func       <= cur_beat.fn;
          index_0    <= cur_beat.idx[0];
          index_1    <= cur_beat.idx[1];
          index_2    <= cur_beat.idx[2];
          index_3    <= cur_beat.idx[3];
          write_data <= cur_beat.wdata;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // reply monitor
  always @(posedge clk) begin
    elem_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (element_replies.size() == 0) begin
        reply_errors++;
        if (reply_errors <= 10)
          $display("unexpected reply beat: read_data %h status %0d", read_data, status);
      end else begin
        want = element_replies.pop_front();
        if (read_data !== want.rdata || status !== want.st) begin
          reply_errors++;
          if (reply_errors <= 10)
            $display("reply mismatch: read_data exp %h got %h, status exp %0d got %0d",
                     want.rdata, read_data, want.st, status);
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: zero extents, every access is an index error
    add_access(FUNC_WRITE, 0, 0, 0, 0, 32'h1234_5678);
    add_access(FUNC_READ, 4095, 4095, 4095, 4095, '0);
    add_random_accesses(10);
    wait_drained();

    // one dimension covering the whole store, value extremes
    set_geometry(1, 4096, 5, 6, 7);
    add_access(FUNC_WRITE, 0, 0, 0, 0, 32'h7fff_ffff);
    add_access(FUNC_WRITE, 4095, 0, 0, 0, 32'h8000_0000);
    add_access(FUNC_WRITE, 1, 0, 0, 0, 32'hffff_ffff);
    add_access(FUNC_WRITE, 2, 0, 0, 0, 32'h0000_0000);
    add_access(FUNC_READ, 0, 0, 0, 0, '0);
    add_access(FUNC_READ, 4095, 4095, 4095, 4095, '0);
    add_access(FUNC_READ, 1, 0, 0, 0, '0);
    add_access(FUNC_READ, 2, 0, 0, 0, '0);
    add_random_accesses(80);
    wait_drained();

    // writes to unused register numbers, then zero dimensions and a wide extent
    for (int r = REG_EXT_3 + 1; r < (1 << CFG_IDX_W); r++)
      write_reg(CFG_IDX_W'(r), $urandom_range(0, 8191));
    set_geometry(0, 8191, 4096, 0, 1);
    add_access(FUNC_READ, 4095, 0, 0, 0, '0);
    add_random_accesses(60);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 35;

    // two dimensions larger than the store; high bits set in the dimension count
    set_geometry(2 | ($urandom_range(1, 1023) << 3), 100, 50, 3, 3);
    add_access(FUNC_WRITE, 0, 0, 0, 0, 32'ha5a5_a5a5);
    add_access(FUNC_WRITE, 100, 0, 0, 0, 32'h1111_1111);
    add_access(FUNC_WRITE, 0, 50, 0, 0, 32'h0);
    add_access(FUNC_READ, 0, 0, 0, 0, '0);
    add_access(FUNC_WRITE, 99, 49, 0, 0, 32'h2222_2222);
    add_access(FUNC_READ, 81, 46, 0, 0, '0);
    add_random_accesses(70);
    wait_drained();

    set_geometry(3, 20, 15, 13, 2);
    add_random_accesses(70);
    wait_drained();

    set_geometry(4, 7, 9, 8, 6);
    add_random_accesses(70);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;

    // dimension count above the limit saturates to four
    set_geometry(7, 16, 16, 16, 17);
    add_random_accesses(80);
    wait_drained();

    // largest extents everywhere
    set_geometry(4, 8191, 8191, 8191, 8191);
    add_access(FUNC_WRITE, 0, 0, 0, 4095, 32'h0000_0001);
    add_access(FUNC_READ, 0, 0, 0, 4095, '0);
    add_access(FUNC_READ, 4095, 4095, 4095, 4095, '0);
    add_random_accesses(40);
    wait_drained();

    // zero extent on the second dimension
    set_geometry(2, 3, 0, 9, 9);
    add_random_accesses(30);
    wait_drained();

    if (reply_errors == 0) begin
      $display("multidim_array_address_store_core regression: pass");
    end else begin
      $display("multidim_array_address_store_core regression: fail");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("multidim_array_address_store_core regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mdas_pkg.sv
hw/rtl/mdas_ram.sv
hw/rtl/mdas_front.sv
hw/rtl/mdas_queue.sv
hw/rtl/mdas_back.sv
hw/rtl/multidim_array_address_store_core.sv
hw/rtl/mdas_checker.sv
test/tb_multidim_array_address_store_core.sv
